// ===== hw/rtl/utc_pkg.sv =====
`default_nettype none
package utc_pkg;

  // pipeline depth, input register to output register
  localparam int unsigned NSTG = 12;

  localparam int unsigned SEC_W   = 36;
  localparam int unsigned DAY_W   = 20;
  localparam int unsigned A_W     = 22;
  localparam int unsigned RSEC_W  = 17;

  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned MDAY_W  = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SECF_W  = 6;

  // one load enable per pipeline stage
  typedef logic [NSTG-1:0] utc_ld_t;

endpackage
`default_nettype wire

// ===== hw/rtl/utc_pipe_ctrl.sv =====
`default_nettype none
module utc_pipe_ctrl import utc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output utc_ld_t ld
);

  localparam utc_ld_t FULL = '1;

  utc_ld_t v_r;
  utc_ld_t v_nxt;
  utc_ld_t src;

  // a stage loads unless it and every stage after it hold a word and the sink stalls
  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      ld[k] = out_ready || ((v_r >> k) != (FULL >> k));
    end
  end

  assign src   = {v_r[NSTG-2:0], in_valid};
  assign v_nxt = (ld & src) | (~ld & v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = v_r[NSTG-1];

endmodule
`default_nettype wire

// ===== hw/rtl/utc_dsplit.sv =====
`default_nettype none
module utc_dsplit import utc_pkg::*; (
  input  logic             clk,
  input  utc_ld_t          ld,
  input  logic [SEC_W-1:0] secs,
  output logic [A_W-1:0]   jdn_a,
  output logic [RSEC_W-1:0] rsec
);

  // seconds / 86400 as (seconds >> 7) / 675, reciprocal 2^29 / 675
  localparam int unsigned DIV_SH  = 7;
  localparam int unsigned X_W     = SEC_W - DIV_SH;
  localparam int unsigned RECIP_W = 20;
  localparam int unsigned PROD_W  = X_W + RECIP_W;
  localparam int unsigned RECIP   = 795364;
  localparam int unsigned SPD     = 86400;
  localparam int unsigned REM_W   = 18;
  // epoch day number plus the first offset of the date method
  localparam int unsigned JDN_OFF = 2440588 + 68569;

  logic [PROD_W-1:0] prod1;
  logic [DAY_W-1:0]  s1_dq_r;
  logic [SEC_W-1:0]  s1_secs_r;

  logic [SEC_W-1:0]  mul2;
  logic [SEC_W-1:0]  diff2;
  logic [DAY_W-1:0]  s2_dq_r;
  logic [REM_W-1:0]  s2_rem_r;

  logic              ge3;
  logic [REM_W-1:0]  rem3;
  logic [A_W-1:0]    s3_a_r;
  logic [RSEC_W-1:0] s3_rsec_r;

  assign prod1 = PROD_W'(secs[SEC_W-1:DIV_SH]) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s1_dq_r   <= prod1[PROD_W-1:X_W];
      s1_secs_r <= secs;
    end
  end

  // estimate is low by at most one day
  assign mul2  = SEC_W'(s1_dq_r) * SEC_W'(SPD);
  assign diff2 = s1_secs_r - mul2;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s2_dq_r  <= s1_dq_r;
      s2_rem_r <= diff2[REM_W-1:0];
    end
  end

  assign ge3  = s2_rem_r >= REM_W'(SPD);
  assign rem3 = ge3 ? s2_rem_r - REM_W'(SPD) : s2_rem_r;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s3_a_r    <= A_W'(s2_dq_r) + A_W'(JDN_OFF) + A_W'(ge3);
      s3_rsec_r <= rem3[RSEC_W-1:0];
    end
  end

  assign jdn_a = s3_a_r;
  assign rsec  = s3_rsec_r;

endmodule
`default_nettype wire

// ===== hw/rtl/utc_date.sv =====
`default_nettype none
module utc_date import utc_pkg::*; (
  input  logic               clk,
  input  utc_ld_t            ld,
  input  logic [A_W-1:0]     jdn_a,
  output logic [YEAR_W-1:0]  year,
  output logic [MONTH_W-1:0] month,
  output logic [MDAY_W-1:0]  mday
);

  localparam int unsigned C_W  = 7;
  localparam int unsigned A2_W = 16;
  localparam int unsigned A3_W = 10;
  localparam int unsigned MQ_W = 4;

  localparam int unsigned GCYC     = 146097;
  localparam int unsigned GCYC_REC = 114;     // 2^24 / 146097, taken on 4a
  localparam int unsigned YCYC     = 1461001;
  localparam int unsigned YMUL     = 4000;
  localparam int unsigned YCYC_REC = 179;     // 4000 * 2^16 / 1461001
  localparam int unsigned QCYC     = 1461;
  localparam int unsigned MCYC     = 2447;
  localparam int unsigned MMUL     = 80;
  localparam int unsigned MCYC_REC = 33;      // 80 * 2^10 / 2447
  localparam int unsigned YEAR_OFF = 6800;    // 4900 century bias plus 1900
  localparam logic [MQ_W-1:0] MQ_WRAP = 4'd11;

  // (2447 * m) / 80
  localparam logic [8:0] MDAY_OFF [16] = '{
    9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd152, 9'd183, 9'd214,
    9'd244, 9'd275, 9'd305, 9'd336, 9'd367, 9'd397, 9'd428, 9'd458
  };

  // stage 4
  logic [28:0]      p4;
  logic [C_W-1:0]   s4_cest_r;
  logic [A_W-1:0]   s4_a_r;
  // stage 5
  logic [23:0]      r5;
  logic [C_W-1:0]   s5_cest_r;
  logic [18:0]      s5_r_r;
  // stage 6
  logic             ge6;
  logic [18:0]      r6;
  logic [C_W-1:0]   s6_cent_r;
  logic [A2_W-1:0]  s6_a2_r;
  // stage 7
  logic [16:0]      y7;
  logic [24:0]      p7;
  logic [13:0]      yb7;
  logic [C_W-1:0]   s7_yest_r;
  logic [A2_W-1:0]  s7_a2_r;
  logic [YEAR_W-1:0] s7_yb_r;
  // stage 8
  logic [16:0]      y8;
  logic [27:0]      t8;
  logic             ge8;
  logic [C_W-1:0]   s8_yq_r;
  logic [A2_W-1:0]  s8_a2_r;
  logic [YEAR_W-1:0] s8_yb_r;
  // stage 9
  logic [17:0]      q9;
  logic [16:0]      a3w;
  logic [A3_W-1:0]  s9_a3_r;
  logic [C_W-1:0]   s9_yq_r;
  logic [YEAR_W-1:0] s9_yb_r;
  // stage 10
  logic [15:0]      p10;
  logic [MQ_W-1:0]  s10_mest_r;
  logic [A3_W-1:0]  s10_a3_r;
  logic [C_W-1:0]   s10_yq_r;
  logic [YEAR_W-1:0] s10_yb_r;
  // stage 11
  logic [16:0]      t11;
  logic             ge11;
  logic [MQ_W-1:0]  s11_mq_r;
  logic [A3_W-1:0]  s11_a3_r;
  logic [C_W-1:0]   s11_yq_r;
  logic [YEAR_W-1:0] s11_yb_r;
  // stage 12
  logic             carry12;
  logic [A3_W-1:0]  dy12;
  logic [YEAR_W-1:0] year_r;
  logic [MONTH_W-1:0] month_r;
  logic [MDAY_W-1:0] mday_r;

  // century estimate, low by at most one
  assign p4 = 29'(jdn_a) * 29'(GCYC_REC);

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s4_cest_r <= p4[28:22];
      s4_a_r    <= jdn_a;
    end
  end

  assign r5 = {s4_a_r, 2'b00} - 24'(s4_cest_r) * 24'(GCYC);

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      s5_cest_r <= s4_cest_r;
      s5_r_r    <= r5[18:0];
    end
  end

  // day within the century is the remainder of 4a over the cycle, divided by four
  assign ge6 = s5_r_r >= 19'(GCYC);
  assign r6  = ge6 ? s5_r_r - 19'(GCYC) : s5_r_r;

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      s6_cent_r <= s5_cest_r + C_W'(ge6);
      s6_a2_r   <= r6[17:2];
    end
  end

  assign y7  = 17'(s6_a2_r) + 17'd1;
  assign p7  = 25'(y7) * 25'(YCYC_REC);
  assign yb7 = 14'(s6_cent_r) * 14'(100) - 14'(YEAR_OFF);

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      s7_yest_r <= p7[22:16];
      s7_a2_r   <= s6_a2_r;
      s7_yb_r   <= yb7[YEAR_W-1:0];
    end
  end

  assign y8  = 17'(s7_a2_r) + 17'd1;
  assign t8  = 28'(y8) * 28'(YMUL) - 28'(s7_yest_r) * 28'(YCYC);
  assign ge8 = t8 >= 28'(YCYC);

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      s8_yq_r <= s7_yest_r + C_W'(ge8);
      s8_a2_r <= s7_a2_r;
      s8_yb_r <= s7_yb_r;
    end
  end

  assign q9  = 18'(s8_yq_r) * 18'(QCYC);
  assign a3w = 17'(s8_a2_r) + 17'd31 - 17'(q9[17:2]);

  always_ff @(posedge clk) begin
    if (ld[8]) begin
      s9_a3_r <= a3w[A3_W-1:0];
      s9_yq_r <= s8_yq_r;
      s9_yb_r <= s8_yb_r;
    end
  end

  // month estimate, counted from march
  assign p10 = 16'(s9_a3_r) * 16'(MCYC_REC);

  always_ff @(posedge clk) begin
    if (ld[9]) begin
      s10_mest_r <= p10[13:10];
      s10_a3_r   <= s9_a3_r;
      s10_yq_r   <= s9_yq_r;
      s10_yb_r   <= s9_yb_r;
    end
  end

  assign t11  = 17'(s10_a3_r) * 17'(MMUL) - 17'(s10_mest_r) * 17'(MCYC);
  assign ge11 = t11 >= 17'(MCYC);

  always_ff @(posedge clk) begin
    if (ld[10]) begin
      s11_mq_r <= s10_mest_r + MQ_W'(ge11);
      s11_a3_r <= s10_a3_r;
      s11_yq_r <= s10_yq_r;
      s11_yb_r <= s10_yb_r;
    end
  end

  // january and february belong to the following year
  assign carry12 = s11_mq_r >= MQ_WRAP;
  assign dy12    = s11_a3_r - A3_W'(MDAY_OFF[s11_mq_r]);

  always_ff @(posedge clk) begin
    if (ld[11]) begin
      year_r  <= s11_yb_r + YEAR_W'(s11_yq_r) + YEAR_W'(carry12);
      month_r <= carry12 ? s11_mq_r - MQ_WRAP : s11_mq_r + 4'd1;
      mday_r  <= dy12[MDAY_W-1:0];
    end
  end

  assign year  = year_r;
  assign month = month_r;
  assign mday  = mday_r;

endmodule
`default_nettype wire

// ===== hw/rtl/utc_clock.sv =====
`default_nettype none
module utc_clock import utc_pkg::*; (
  input  logic              clk,
  input  utc_ld_t           ld,
  input  logic [RSEC_W-1:0] rsec,
  output logic [HOUR_W-1:0] hour,
  output logic [MIN_W-1:0]  minute,
  output logic [SECF_W-1:0] second
);

  localparam int unsigned MT_W   = 11;
  localparam int unsigned R_W    = 7;
  localparam int unsigned SIXTY  = 60;
  localparam int unsigned REC_S  = 2184;  // 2^17 / 60
  localparam int unsigned REC_M  = 34;    // 2^11 / 60
  localparam int unsigned HMS_W  = HOUR_W + MIN_W + SECF_W;

  // stage 4
  logic [28:0]        p4;
  logic [MT_W-1:0]    s4_mest_r;
  logic [RSEC_W-1:0]  s4_rsec_r;
  // stage 5
  logic [RSEC_W-1:0]  r5;
  logic [MT_W-1:0]    s5_mest_r;
  logic [R_W-1:0]     s5_rem_r;
  // stage 6
  logic               ge6;
  logic [R_W-1:0]     sec6;
  logic [MT_W-1:0]    s6_mt_r;
  logic [SECF_W-1:0]  s6_sec_r;
  // stage 7
  logic [16:0]        p7;
  logic [HOUR_W-1:0]  s7_hest_r;
  logic [MT_W-1:0]    s7_mt_r;
  logic [SECF_W-1:0]  s7_sec_r;
  // stage 8
  logic [MT_W-1:0]    r8;
  logic [HOUR_W-1:0]  s8_hest_r;
  logic [R_W-1:0]     s8_rem_r;
  logic [SECF_W-1:0]  s8_sec_r;
  // stage 9
  logic               ge9;
  logic [R_W-1:0]     min9;
  logic [HMS_W-1:0]   s9_hms_r;
  // stages 10 to 12 only carry the result alongside the date
  logic [HMS_W-1:0]   dl_r [3];

  assign p4 = 29'(rsec) * 29'(REC_S);

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s4_mest_r <= p4[27:17];
      s4_rsec_r <= rsec;
    end
  end

  assign r5 = s4_rsec_r - RSEC_W'(s4_mest_r) * RSEC_W'(SIXTY);

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      s5_mest_r <= s4_mest_r;
      s5_rem_r  <= r5[R_W-1:0];
    end
  end

  assign ge6  = s5_rem_r >= R_W'(SIXTY);
  assign sec6 = ge6 ? s5_rem_r - R_W'(SIXTY) : s5_rem_r;

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      s6_mt_r  <= s5_mest_r + MT_W'(ge6);
      s6_sec_r <= sec6[SECF_W-1:0];
    end
  end

  // minute of the day split into hour and minute
  assign p7 = 17'(s6_mt_r) * 17'(REC_M);

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      s7_hest_r <= p7[15:11];
      s7_mt_r   <= s6_mt_r;
      s7_sec_r  <= s6_sec_r;
    end
  end

  assign r8 = s7_mt_r - MT_W'(s7_hest_r) * MT_W'(SIXTY);

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      s8_hest_r <= s7_hest_r;
      s8_rem_r  <= r8[R_W-1:0];
      s8_sec_r  <= s7_sec_r;
    end
  end

  assign ge9  = s8_rem_r >= R_W'(SIXTY);
  assign min9 = ge9 ? s8_rem_r - R_W'(SIXTY) : s8_rem_r;

  always_ff @(posedge clk) begin
    if (ld[8]) begin
      s9_hms_r <= {s8_hest_r + HOUR_W'(ge9), min9[MIN_W-1:0], s8_sec_r};
    end
  end

  always_ff @(posedge clk) begin
    if (ld[9]) begin
      dl_r[0] <= s9_hms_r;
    end
    if (ld[10]) begin
      dl_r[1] <= dl_r[0];
    end
    if (ld[11]) begin
      dl_r[2] <= dl_r[1];
    end
  end

  assign hour   = dl_r[2][HMS_W-1 -: HOUR_W];
  assign minute = dl_r[2][SECF_W +: MIN_W];
  assign second = dl_r[2][SECF_W-1:0];

endmodule
`default_nettype wire

// ===== hw/rtl/unix_time_to_calendar.sv =====
// throughput: one word per cycle unless the sink stalls; each stage moves on when the
//   stage after it has room, so bubbles close up and input is taken while a result
//   waits at the output
// cost per stage: constant multiplies with subtracts, a table lookup, or a compare-and-correct step
// reset: synchronous, active low; clears the stage valid bits only, no clearing pass
`default_nettype none
module unix_time_to_calendar import utc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SEC_W-1:0]   in_unix_seconds,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [YEAR_W-1:0]  out_year_since_1900,
  output logic [MONTH_W-1:0] out_month_index,
  output logic [MDAY_W-1:0]  out_day_of_month,
  output logic [HOUR_W-1:0]  out_hour_of_day,
  output logic [MIN_W-1:0]   out_minute_of_hour,
  output logic [SECF_W-1:0]  out_second_of_minute
);

  utc_ld_t           ld;
  logic [A_W-1:0]    jdn_a;
  logic [RSEC_W-1:0] rsec;

  utc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ld        (ld)
  );

  utc_dsplit u_dsplit (
    .clk   (clk),
    .ld    (ld),
    .secs  (in_unix_seconds),
    .jdn_a (jdn_a),
    .rsec  (rsec)
  );

  utc_date u_date (
    .clk   (clk),
    .ld    (ld),
    .jdn_a (jdn_a),
    .year  (out_year_since_1900),
    .month (out_month_index),
    .mday  (out_day_of_month)
  );

  utc_clock u_clock (
    .clk    (clk),
    .ld     (ld),
    .rsec   (rsec),
    .hour   (out_hour_of_day),
    .minute (out_minute_of_hour),
    .second (out_second_of_minute)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/utc_checker.sv =====
`default_nettype none
module utc_checker import utc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_ready,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [YEAR_W-1:0]  out_year_since_1900,
  input  logic [MONTH_W-1:0] out_month_index,
  input  logic [MDAY_W-1:0]  out_day_of_month,
  input  logic [HOUR_W-1:0]  out_hour_of_day,
  input  logic [MIN_W-1:0]   out_minute_of_hour,
  input  logic [SECF_W-1:0]  out_second_of_minute
);

  logic [YEAR_W+MONTH_W+MDAY_W+HOUR_W+MIN_W+SECF_W-1:0] out_word;

  assign out_word = {out_year_since_1900, out_month_index, out_day_of_month,
                     out_hour_of_day, out_minute_of_hour, out_second_of_minute};

  // a stalled result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word dropped or changed while stalled");

  // a free sink never holds back the input
  a_ready_path: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is free");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word shown straight after reset");

  // every result field lies in range, with the year at 70 or later
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_month_index <= 4'd11 && out_day_of_month != 5'd0 &&
                  out_hour_of_day <= 5'd23 && out_minute_of_hour <= 6'd59 &&
                  out_second_of_minute <= 6'd59 && out_year_since_1900 >= 12'd70)
    else $error("result field out of range");

endmodule

bind unix_time_to_calendar utc_checker u_chk (.*);
`default_nettype wire

// ===== tb/unix_time_to_calendar_chk.sv =====
`timescale 1ns / 1ps
module unix_time_to_calendar_chk import utc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [SEC_W-1:0]   in_unix_seconds,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [YEAR_W-1:0]  out_year_since_1900,
  input  logic [MONTH_W-1:0] out_month_index,
  input  logic [MDAY_W-1:0]  out_day_of_month,
  input  logic [HOUR_W-1:0]  out_hour_of_day,
  input  logic [MIN_W-1:0]   out_minute_of_hour,
  input  logic [SECF_W-1:0]  out_second_of_minute,
  output int unsigned        fail_count,
  output int unsigned        dates_due,
  output int unsigned        dates_seen
);

  localparam longint EPOCH_JDN    = 2440588;
  localparam longint SECS_PER_DAY = 60 * 60 * 24;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [MDAY_W-1:0]  mday;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SECF_W-1:0]  second;
  } utc_date_t;

  utc_date_t   due_dates[$];
  int unsigned errs = 0;
  int unsigned seen = 0;

  // epoch seconds to broken-down utc, julian day number route
  function automatic utc_date_t calendar_of(input logic [SEC_W-1:0] secs);
    longint    s, a, cent, yq, mq, carry;
    utc_date_t r;
    s     = longint'(secs);
    a     = s / SECS_PER_DAY + EPOCH_JDN + 68569;
    cent  = (4 * a) / 146097;
    a     = a - (146097 * cent + 3) / 4;
    yq    = (4000 * (a + 1)) / 1461001;
    a     = a - (1461 * yq) / 4 + 31;
    mq    = (80 * a) / 2447;
    carry = mq / 11;
    r.mday   = MDAY_W'(a - (2447 * mq) / 80);
    r.month  = MONTH_W'(mq + 2 - 12 * carry - 1);
    r.year   = YEAR_W'(100 * (cent - 49) + yq + carry - 1900);
    r.hour   = HOUR_W'((s / 3600) % 24);
    r.minute = MIN_W'((s / 60) % 60);
    r.second = SECF_W'(s % 60);
    return r;
  endfunction

  always @(posedge clk) begin
    utc_date_t got;
    utc_date_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        due_dates.push_back(calendar_of(in_unix_seconds));
      end
      if (out_valid && out_ready) begin
        got = '{out_year_since_1900, out_month_index, out_day_of_month,
                out_hour_of_day, out_minute_of_hour, out_second_of_minute};
        if (due_dates.size() == 0) begin
          errs++;
          if (errs <= REPORT_MAX) begin
            $display("[%0t] date word with none outstanding: y=%0d m=%0d d=%0d %0d:%0d:%0d",
                     $realtime, got.year, got.month, got.mday, got.hour, got.minute,
                     got.second);
          end
        end else begin
          want = due_dates.pop_front();
          seen++;
          if (want != got) begin
            errs++;
            if (errs <= REPORT_MAX) begin
              $display("[%0t] date %0d mismatch: expected y=%0d m=%0d d=%0d %0d:%0d:%0d",
                       $realtime, seen, want.year, want.month, want.mday, want.hour,
                       want.minute, want.second);
              $display("          got      y=%0d m=%0d d=%0d %0d:%0d:%0d",
                       got.year, got.month, got.mday, got.hour, got.minute, got.second);
            end
          end
        end
      end
    end
    fail_count <= errs;
    dates_due  <= due_dates.size();
    dates_seen <= seen;
  end

endmodule

// ===== tb/unix_time_to_calendar_tb.sv =====
`timescale 1ns / 1ps
module unix_time_to_calendar_tb;
  import utc_pkg::*;

  localparam int unsigned RAND_WORDS  = 1600;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [SEC_W-1:0] SEC_MAX = '1;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [SEC_W-1:0]   in_unix_seconds = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [YEAR_W-1:0]  out_year_since_1900;
  logic [MONTH_W-1:0] out_month_index;
  logic [MDAY_W-1:0]  out_day_of_month;
  logic [HOUR_W-1:0]  out_hour_of_day;
  logic [MIN_W-1:0]   out_minute_of_hour;
  logic [SECF_W-1:0]  out_second_of_minute;

  int unsigned fail_count;
  int unsigned dates_due;
  int unsigned dates_seen;
  int unsigned words_sent = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;

  unix_time_to_calendar DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_unix_seconds      (in_unix_seconds),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_year_since_1900  (out_year_since_1900),
    .out_month_index      (out_month_index),
    .out_day_of_month     (out_day_of_month),
    .out_hour_of_day      (out_hour_of_day),
    .out_minute_of_hour   (out_minute_of_hour),
    .out_second_of_minute (out_second_of_minute)
  );

  unix_time_to_calendar_chk chk (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_unix_seconds      (in_unix_seconds),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_year_since_1900  (out_year_since_1900),
    .out_month_index      (out_month_index),
    .out_day_of_month     (out_day_of_month),
    .out_hour_of_day      (out_hour_of_day),
    .out_minute_of_hour   (out_minute_of_hour),
    .out_second_of_minute (out_second_of_minute),
    .fail_count           (fail_count),
    .dates_due            (dates_due),
    .dates_seen           (dates_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d dates still outstanding", cycles, dates_due);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // valid stays up across back-to-back words, only dropped when a gap is drawn
  task automatic send_word(input logic [SEC_W-1:0] secs);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_unix_seconds <= secs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // result side back-pressure
  initial begin
    int unsigned stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    longint unsigned day_no;
    longint unsigned t;
    int unsigned     pick;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // calendar edges: epoch, minute/hour/day rollovers, leap days, century rules
    send_word(36'd0);
    send_word(36'd1);
    send_word(36'd59);
    send_word(36'd60);
    send_word(36'd3599);
    send_word(36'd3600);
    send_word(36'd86399);
    send_word(36'd86400);
    send_word(36'd31535999);
    send_word(36'd68169600);
    send_word(36'd946684799);
    send_word(36'd951782399);
    send_word(36'd951782400);
    send_word(36'd951868800);
    send_word(36'd2147483647);
    send_word(36'd4107542399);
    send_word(36'd4107542400);
    send_word(36'd13574563200);
    send_word(36'h800000000);
    send_word(36'hAAAAAAAAA);
    send_word(36'h555555555);
    send_word(SEC_MAX);

    for (int unsigned n = 0; n < RAND_WORDS; n++) begin
      // stretches with no idling on either side
      calm = (n % 400) >= 320;
      pick = $urandom_range(0, 99);
      if (pick < 52) begin
        t = {$urandom_range(0, 15), $urandom()};
      end else if (pick < 74) begin
        day_no = $urandom_range(0, 795363);
        case ($urandom_range(0, 3))
          0: t = day_no * 86400;
          1: t = day_no * 86400 + 86399;
          2: t = day_no * 86400 + 1;
          default: t = day_no * 86400 + $urandom_range(0, 23) * 3600 + 3599;
        endcase
      end else if (pick < 88) begin
        t = $urandom();
      end else if (pick < 96) begin
        t = $urandom_range(0, 1 << 20);
      end else begin
        t = SEC_MAX - $urandom_range(0, 200000);
      end
      send_word(t[SEC_W-1:0]);
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    @(posedge clk);
    while (dates_due != 0) @(posedge clk);
    repeat (NSTG + 4) @(posedge clk);

    $display("%0d timestamps sent (22 calendar edge cases, rest random over the 36-bit range),",
             words_sent);
    $display("%0d dates checked with random gaps and stalls on both channels", dates_seen);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d failures", fail_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/utc_pkg.sv
hw/rtl/utc_pipe_ctrl.sv
hw/rtl/utc_dsplit.sv
hw/rtl/utc_date.sv
hw/rtl/utc_clock.sv
hw/rtl/unix_time_to_calendar.sv
hw/rtl/utc_checker.sv
tb/unix_time_to_calendar_chk.sv
tb/unix_time_to_calendar_tb.sv
